// File: rtl/core/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants of the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

    localparam int DEPTH      = 64;
    localparam int KEY_W      = 32;
    localparam int PAY_W      = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 7;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = CFG_IDX_W'(1);

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             en;
        t_action          action;
        logic             descending;
        logic [CNT_W-1:0] count;
        t_entry           item;
    } t_cell_ctrl;

endpackage

// File: rtl/core/ssq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_in_if
// Request channel: insert or remove, with key and payload.
// ----------------------------------------------------------------------------
interface ssq_in_if;
    logic                     valid;
    logic                     ready;
    ssq_pkg::t_action         action;
    logic [ssq_pkg::KEY_W-1:0] item_key;
    logic [ssq_pkg::PAY_W-1:0] item_payload;

    modport source (output valid, output action, output item_key, output item_payload,
                    input ready);
    modport sink   (input valid, input action, input item_key, input item_payload,
                    output ready);
endinterface

// File: rtl/core/ssq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_out_if
// Result channel: head or removed entry and queue status.
// ----------------------------------------------------------------------------
interface ssq_out_if;
    logic                      valid;
    logic                      ready;
    logic                      out_valid;
    logic [ssq_pkg::KEY_W-1:0] out_key;
    logic [ssq_pkg::PAY_W-1:0] out_payload;
    logic [ssq_pkg::CAP_W-1:0] entry_count;
    logic                      is_empty;
    logic                      is_full;
    logic [ssq_pkg::CAP_W-1:0] peak_count;
    logic                      dropped;
    logic                      underflow;

    modport source (output valid, output out_valid, output out_key, output out_payload,
                    output entry_count, output is_empty, output is_full,
                    output peak_count, output dropped, output underflow,
                    input ready);
    modport sink   (input valid, input out_valid, input out_key, input out_payload,
                    input entry_count, input is_empty, input is_full,
                    input peak_count, input dropped, input underflow,
                    output ready);
endinterface

// File: rtl/core/ssq_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ssq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ssq_pkg::CFG_IDX_W-1:0]  index;
    logic [ssq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ssq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: holds an entry, compares it with the new
// key and loads from its left or right neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module ssq_cell (
    input  logic                      i_clk,
    input  ssq_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ssq_pkg::CNT_W-1:0] i_index,
    input  logic                      i_prev_hit,
    input  ssq_pkg::t_entry           i_left,
    input  ssq_pkg::t_entry           i_right,
    output logic                      o_hit,
    output ssq_pkg::t_entry           o_entry,
    output ssq_pkg::t_entry           o_next
);

    ssq_pkg::t_entry r_entry;
    ssq_pkg::t_entry n_entry;
    logic            occupied;
    logic            precedes;
    logic            lands_here;

    assign occupied   = (i_index < i_ctrl.count);
    assign precedes   = i_ctrl.descending ? (i_ctrl.item.key > r_entry.key)
                                          : (i_ctrl.item.key < r_entry.key);
    assign lands_here = occupied & precedes;
    // Once some cell to the left has taken the new item, every later cell shifts.
    assign o_hit      = i_prev_hit | lands_here;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.action)
            ssq_pkg::ACT_INSERT: begin
                if (i_prev_hit) begin
                    n_entry = i_left;
                end else if (lands_here || (i_index == i_ctrl.count)) begin
                    n_entry = i_ctrl.item;
                end
            end
            ssq_pkg::ACT_REMOVE: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// File: rtl/core/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept sorted in a chain of cells, stable on ties.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Contents
//  i_in      in   valid/ready    action, item_key, item_payload
//  o_out     out  valid/ready    head or removed entry, count, flags, peak
//  i_cfg     in   valid/ready    register index, write data (always ready)
//
// In each request transaction every cell compares its key with the new key
// at once and the whole chain shifts in the same edge.
// The result lands in an output register; a new request is taken whenever
// that register is empty or its transaction completes in the same cycle, so
// a stalled result channel holds the input off and nothing else.
// Reset clears the entry count and the peak count and sets the configuration
// registers to ascending order and a capacity of 64; the cell contents are not cleared and are only read below count.
//
// Structure: DEPTH identical cells. Cell 0 is the head. On insert, the first
// occupied cell whose key the new key strictly precedes takes the new item
// and all cells to its right take their left neighbor; with no such cell the
// item goes into the first free cell. On remove, every cell takes its right
// neighbor. When the queue is at capacity the count stays put, so whatever
// shifts past the last counted cell is lost, which is the drop.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ssq_in_if.sink    i_in,
    ssq_out_if.source o_out,
    ssq_cfg_if.sink   i_cfg
);

    localparam int DEPTH = ssq_pkg::DEPTH;
    localparam int CNT_W = ssq_pkg::CNT_W;
    localparam int CAP_W = ssq_pkg::CAP_W;
    localparam int CMP_W = ssq_pkg::CMP_W;

    // Configuration registers.
    logic             r_descending;
    logic [CAP_W-1:0] r_capacity;

    // Queue control state.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_peak;
    logic [CNT_W-1:0] n_peak;

    // Output register.
    logic                      r_out_valid;
    logic                      r_res_valid;
    logic [ssq_pkg::KEY_W-1:0] r_res_key;
    logic [ssq_pkg::PAY_W-1:0] r_res_payload;
    logic [CNT_W-1:0]          r_res_count;
    logic                      r_res_full;
    logic [CNT_W-1:0]          r_res_peak;
    logic                      r_res_dropped;
    logic                      r_res_underflow;

    logic                      n_res_valid;
    ssq_pkg::t_entry           n_res_entry;
    logic                      n_res_full;
    logic                      n_res_dropped;
    logic                      n_res_underflow;

    logic                      accept;
    logic [CMP_W-1:0]          cap_ext;
    logic [CNT_W-1:0]          eff_cap;
    logic                      at_cap;

    ssq_pkg::t_cell_ctrl       ctrl;
    logic                      hit   [DEPTH+1];
    ssq_pkg::t_entry           entry [DEPTH];
    ssq_pkg::t_entry           nxt   [DEPTH];

    // The configuration port never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
            r_capacity   <= CAP_W'(64);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ssq_pkg::CFG_DESCENDING: r_descending <= i_cfg.data[0];
                ssq_pkg::CFG_CAPACITY:   r_capacity   <= i_cfg.data[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A capacity of zero acts as one, and one above the depth acts as the depth.
    always_comb begin
        cap_ext = CMP_W'(r_capacity);
        if (cap_ext == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = cap_ext[CNT_W-1:0];
        end
    end

    assign at_cap     = (r_count >= eff_cap);
    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign accept     = i_in.valid & i_in.ready;

    assign ctrl.en           = accept;
    assign ctrl.action       = i_in.action;
    assign ctrl.descending   = r_descending;
    assign ctrl.count        = r_count;
    assign ctrl.item.key     = i_in.item_key;
    assign ctrl.item.payload = i_in.item_payload;

    assign hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ssq_pkg::t_entry left;
        ssq_pkg::t_entry right;

        if (g == 0) begin : g_head
            assign left = ctrl.item;
        end else begin : g_body
            assign left = entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right = entry[g];
        end else begin : g_mid
            assign right = entry[g+1];
        end

        ssq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_index    (CNT_W'(g)),
            .i_prev_hit (hit[g]),
            .i_left     (left),
            .i_right    (right),
            .o_hit      (hit[g+1]),
            .o_entry    (entry[g]),
            .o_next     (nxt[g])
        );
    end

    // Count, flags and the result for the transaction being taken.
    always_comb begin
        n_count         = r_count;
        n_res_valid     = 1'b0;
        n_res_entry     = '0;
        n_res_dropped   = 1'b0;
        n_res_underflow = 1'b0;
        unique case (i_in.action)
            ssq_pkg::ACT_INSERT: begin
                n_res_valid = 1'b1;
                n_res_entry = nxt[0];
                if (at_cap) begin
                    n_res_dropped = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ssq_pkg::ACT_REMOVE: begin
                if (r_count == '0) begin
                    n_res_underflow = 1'b1;
                end else begin
                    n_res_valid = 1'b1;
                    n_res_entry = entry[0];
                    n_count     = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_peak     = (n_count > r_peak) ? n_count : r_peak;
        n_res_full = (n_count >= eff_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_peak  <= n_peak;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_valid     <= n_res_valid;
            r_res_key       <= n_res_entry.key;
            r_res_payload   <= n_res_entry.payload;
            r_res_count     <= n_count;
            r_res_full      <= n_res_full;
            r_res_peak      <= n_peak;
            r_res_dropped   <= n_res_dropped;
            r_res_underflow <= n_res_underflow;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_valid   = r_res_valid;
    assign o_out.out_key     = r_res_key;
    assign o_out.out_payload = r_res_payload;
    assign o_out.entry_count = CAP_W'(r_res_count);
    assign o_out.is_empty    = (r_res_count == '0);
    assign o_out.is_full     = r_res_full;
    assign o_out.peak_count  = CAP_W'(r_res_peak);
    assign o_out.dropped     = r_res_dropped;
    assign o_out.underflow   = r_res_underflow;

endmodule
